// ===== sv/urfp_pkg.sv =====
// ----------------------------------------------------------------------------
// urfp_pkg
// Shared types, constants and the baud rate table of the UART receive FIFO
// port block.
// ----------------------------------------------------------------------------
package urfp_pkg;

  localparam int FIFO_DEPTH = 1024;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  localparam int TMO_W = 20;
  localparam int BAUD_W = 20;
  localparam logic [TMO_W-1:0] TIMEOUT_RESET = 20'd50000;

  localparam logic [1:0] OP_RX_BYTE = 2'd0;
  localparam logic [1:0] OP_READ    = 2'd1;
  localparam logic [1:0] OP_WRITE   = 2'd2;
  localparam logic [1:0] OP_TICK    = 2'd3;

  localparam logic PORT_DATA   = 1'b0;
  localparam logic PORT_STATUS = 1'b1;

  localparam logic [7:0] CMD_MAX_SPEED = 8'd9;
  localparam logic [7:0] CMD_CLEAR     = 8'd20;

  localparam logic [7:0] STAT_NOT_EMPTY = 8'h01;
  localparam logic [7:0] STAT_CONST     = 8'h08;
  localparam logic [7:0] STAT_UNDERRUN  = 8'h10;
  localparam logic [7:0] UNDERRUN_BYTE  = 8'hFF;

  typedef struct packed {
    logic push;
    logic pop;
    logic clear;
  } fifo_cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } fifo_stat_t;

  typedef struct packed {
    logic              rx_dropped;
    logic [BAUD_W-1:0] baud_rate;
    logic              cpu_wait;
    logic [7:0]        tx_byte;
    logic              tx_valid;
    logic [7:0]        read_data;
    logic              read_valid;
    logic              use_fifo;
  } result_t;

  function automatic logic [BAUD_W-1:0] baud_lookup(input logic [3:0] idx);
    logic [BAUD_W-1:0] rate;
    case (idx)
      4'd0:    rate = 20'd859372;
      4'd1:    rate = 20'd346520;
      4'd2:    rate = 20'd231014;
      4'd3:    rate = 20'd115200;
      4'd4:    rate = 20'd57600;
      4'd5:    rate = 20'd38400;
      4'd6:    rate = 20'd31250;
      4'd7:    rate = 20'd19200;
      4'd8:    rate = 20'd9600;
      4'd9:    rate = 20'd4800;
      default: rate = 20'd859372;
    endcase
    return rate;
  endfunction

endpackage

// ===== sv/urfp_fifo.sv =====
// ----------------------------------------------------------------------------
// urfp_fifo
// Receive byte queue: storage array, head and tail pointers and fill count.
// ----------------------------------------------------------------------------
module urfp_fifo
  import urfp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  fifo_cmd_t  cmd,
  input  logic [7:0] wr_data,
  output fifo_stat_t stat,
  output logic [7:0] rd_data
);

  logic [7:0]       mem [FIFO_DEPTH];
  logic [PTR_W-1:0] head_r, head_nxt;
  logic [PTR_W-1:0] tail_r, tail_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [7:0]       rd_data_r;

  function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign stat.empty = (count_r == '0);
  assign stat.full  = (count_r == CNT_W'(FIFO_DEPTH));
  assign rd_data    = rd_data_r;

  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    if (cmd.clear) begin
      head_nxt  = '0;
      tail_nxt  = '0;
      count_nxt = '0;
    end else if (cmd.push) begin
      tail_nxt  = next_slot(tail_r);
      count_nxt = count_r + CNT_W'(1);
    end else if (cmd.pop) begin
      head_nxt  = next_slot(head_r);
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem[tail_r] <= wr_data;
    end
    if (cmd.pop) begin
      rd_data_r <= mem[head_r];
    end
  end

endmodule

// ===== sv/urfp_ctrl.sv =====
// ----------------------------------------------------------------------------
// urfp_ctrl
// Item decode, stalled read tracking, timeout counter, underrun flag and
// speed selection.
// ----------------------------------------------------------------------------
module urfp_ctrl
  import urfp_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             advance,
  input  logic [1:0]       opcode,
  input  logic             port_select,
  input  logic [7:0]       data_byte,
  input  logic [TMO_W-1:0] timeout,
  input  fifo_stat_t       fifo_stat,
  output fifo_cmd_t        fifo_cmd,
  output result_t          result
);

  logic             pending_r, pending_nxt;
  logic [TMO_W-1:0] wait_cnt_r, wait_cnt_nxt;
  logic             underrun_r, underrun_nxt;
  logic [3:0]       speed_r, speed_nxt;
  logic [TMO_W-1:0] wait_inc;
  fifo_cmd_t        cmd;
  result_t          res;

  assign wait_inc = wait_cnt_r + TMO_W'(1);

  always_comb begin
    pending_nxt  = pending_r;
    wait_cnt_nxt = wait_cnt_r;
    underrun_nxt = underrun_r;
    speed_nxt    = speed_r;
    cmd          = '0;
    res          = '0;
    case (opcode)
      OP_RX_BYTE: begin
        if (pending_r) begin
          pending_nxt    = 1'b0;
          wait_cnt_nxt   = '0;
          res.read_valid = 1'b1;
          res.read_data  = data_byte;
        end else if (fifo_stat.full) begin
          res.rx_dropped = 1'b1;
        end else begin
          cmd.push = 1'b1;
        end
      end
      OP_TICK: begin
        if (pending_r) begin
          if (wait_inc >= timeout || wait_inc == '0) begin
            pending_nxt    = 1'b0;
            wait_cnt_nxt   = '0;
            underrun_nxt   = 1'b1;
            res.read_valid = 1'b1;
            res.read_data  = UNDERRUN_BYTE;
          end else begin
            wait_cnt_nxt = wait_inc;
          end
        end
      end
      OP_READ: begin
        if (!pending_r) begin
          if (port_select == PORT_DATA) begin
            if (!fifo_stat.empty) begin
              cmd.pop        = 1'b1;
              res.read_valid = 1'b1;
              res.use_fifo   = 1'b1;
            end else begin
              pending_nxt  = 1'b1;
              wait_cnt_nxt = '0;
            end
          end else begin
            res.read_data = STAT_CONST
                          | (fifo_stat.empty ? 8'h00 : STAT_NOT_EMPTY)
                          | (underrun_r ? STAT_UNDERRUN : 8'h00);
            res.read_valid = 1'b1;
            underrun_nxt   = 1'b0;
          end
        end
      end
      OP_WRITE: begin
        if (!pending_r) begin
          if (port_select == PORT_DATA) begin
            if (data_byte <= CMD_MAX_SPEED) begin
              speed_nxt = data_byte[3:0];
            end else if (data_byte == CMD_CLEAR) begin
              cmd.clear    = 1'b1;
              underrun_nxt = 1'b0;
            end
          end else begin
            res.tx_valid = 1'b1;
            res.tx_byte  = data_byte;
          end
        end
      end
      default: begin
      end
    endcase
    res.cpu_wait  = pending_nxt;
    res.baud_rate = baud_lookup(speed_nxt);
  end

  assign fifo_cmd = advance ? cmd : '0;
  assign result   = res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r  <= 1'b0;
      wait_cnt_r <= '0;
      underrun_r <= 1'b0;
      speed_r    <= '0;
    end else if (advance) begin
      pending_r  <= pending_nxt;
      wait_cnt_r <= wait_cnt_nxt;
      underrun_r <= underrun_nxt;
      speed_r    <= speed_nxt;
    end
  end

endmodule

// ===== sv/uart_rx_fifo_port_block_unit.sv =====
// ----------------------------------------------------------------------------
// uart_rx_fifo_port_block_unit
// UART receive FIFO with status register behind a two-port bus interface.
//
//   Channel  Direction  Contents
//   in_      slave      tdata: data_byte; tuser: opcode, port_select
//   out_     master     tdata: read/transmit flags and bytes, wait, baud, drop
//   cfg_     write      wait_timeout_ticks
//
// One transfer is accepted per cycle while the result path is not stalled; the item
// is held in the input register, and its result is then registered and offered
// on out_ until out_tready takes it.
// The FIFO pop reads the storage array once per data read that finds the FIFO non-empty.
// While a result is stalled, the input register still takes one transfer if it is empty.
// Reset is synchronous; the storage array needs no clearing pass.
// ----------------------------------------------------------------------------
module uart_rx_fifo_port_block_unit
  import urfp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic [2:0]  in_tuser,   // [1:0] opcode, [2] port_select
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [0] read_valid, [8:1] read_data,
                                  // [9] tx_valid, [17:10] tx_byte,
                                  // [18] cpu_wait, [38:19] baud_rate,
                                  // [39] rx_dropped
  input  logic        cfg_wr_en,
  input  logic [19:0] cfg_wr_data
);

  logic             in_valid_r;
  logic [1:0]       opcode_r;
  logic             port_r;
  logic [7:0]       byte_r;
  logic             out_valid_r;
  result_t          res_r;
  result_t          res_nxt;
  logic [TMO_W-1:0] timeout_r;
  logic             advance;
  fifo_cmd_t        fifo_cmd;
  fifo_stat_t       fifo_stat;
  logic [7:0]       fifo_rd_data;
  logic [7:0]       read_byte;

  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      timeout_r   <= TIMEOUT_RESET;
    end else begin
      if (in_tready) begin
        in_valid_r <= in_tvalid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_wr_en) begin
        timeout_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      opcode_r <= in_tuser[1:0];
      port_r   <= in_tuser[2];
      byte_r   <= in_tdata;
    end
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  urfp_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .advance     (advance),
    .opcode      (opcode_r),
    .port_select (port_r),
    .data_byte   (byte_r),
    .timeout     (timeout_r),
    .fifo_stat   (fifo_stat),
    .fifo_cmd    (fifo_cmd),
    .result      (res_nxt)
  );

  urfp_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (fifo_cmd),
    .wr_data (byte_r),
    .stat    (fifo_stat),
    .rd_data (fifo_rd_data)
  );

  assign read_byte  = res_r.use_fifo ? fifo_rd_data : res_r.read_data;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {res_r.rx_dropped, res_r.baud_rate, res_r.cpu_wait,
                       res_r.tx_byte, res_r.tx_valid, read_byte, res_r.read_valid};

endmodule

// ===== sim/uart_rx_fifo_port_block_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uart_rx_fifo_port_block_unit_test
// Self-checking testbench for the UART receive FIFO port block. A behavioral
// copy of the FIFO, the stalled data read, the status byte, the baud table
// and the command port predicts every result transfer. Directed tests cover
// the reset timeout, each bus access, stalls and FIFO fill and drain; random
// traffic with varied timeouts and random idling on both channels follows.
// ----------------------------------------------------------------------------
module uart_rx_fifo_port_block_unit_test;
  import urfp_pkg::*;

  typedef struct packed {
    logic              read_valid;
    logic [7:0]        read_data;
    logic              tx_valid;
    logic [7:0]        tx_byte;
    logic              cpu_wait;
    logic [BAUD_W-1:0] baud_rate;
    logic              rx_dropped;
  } port_reply_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;
  logic [2:0]  in_tuser = 3'b000;
  logic        out_tvalid;
  logic        out_tready = 1'b1;
  logic [39:0] out_tdata;
  logic        cfg_wr_en = 1'b0;
  logic [19:0] cfg_wr_data = 20'h00000;

  logic [7:0]       rx_bytes [FIFO_DEPTH];
  logic [PTR_W-1:0] rx_head;
  logic [PTR_W-1:0] rx_tail;
  int               rx_fill;
  logic             underrun_seen;
  logic             read_stalled;
  logic [3:0]       speed_sel;
  logic [TMO_W-1:0] stall_ticks;
  logic [TMO_W-1:0] timeout_ticks;

  port_reply_t awaited_replies [16];
  logic [4:0]  reply_wr = 5'd0;
  logic [4:0]  reply_rd = 5'd0;
  port_reply_t want;
  int          mismatch_count = 0;
  bit          idling = 1'b0;

  uart_rx_fifo_port_block_unit uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("FAILURE");
    $finish;
  end

  function automatic logic [BAUD_W-1:0] rate_for(input logic [3:0] sel);
    case (sel)
      4'd1:    return 20'd346520;
      4'd2:    return 20'd231014;
      4'd3:    return 20'd115200;
      4'd4:    return 20'd57600;
      4'd5:    return 20'd38400;
      4'd6:    return 20'd31250;
      4'd7:    return 20'd19200;
      4'd8:    return 20'd9600;
      4'd9:    return 20'd4800;
      default: return 20'd859372;
    endcase
  endfunction

  function automatic port_reply_t port_block_step(input logic [1:0] op, input logic port,
                                                  input logic [7:0] data_byte);
    port_reply_t r;
    r = '0;
    if (op == OP_RX_BYTE) begin
      if (read_stalled) begin
        read_stalled = 1'b0;
        stall_ticks = '0;
        r.read_valid = 1'b1;
        r.read_data = data_byte;
      end else if (rx_fill >= FIFO_DEPTH) begin
        r.rx_dropped = 1'b1;
      end else begin
        rx_bytes[rx_tail] = data_byte;
        rx_tail = rx_tail + PTR_W'(1);
        rx_fill++;
      end
    end else if (op == OP_TICK) begin
      if (read_stalled) begin
        stall_ticks = stall_ticks + TMO_W'(1);
        if (stall_ticks >= timeout_ticks || stall_ticks == '0) begin
          read_stalled = 1'b0;
          stall_ticks = '0;
          underrun_seen = 1'b1;
          r.read_valid = 1'b1;
          r.read_data = UNDERRUN_BYTE;
        end
      end
    end else if (!read_stalled) begin
      if (op == OP_READ && port == PORT_DATA) begin
        if (rx_fill > 0) begin
          r.read_valid = 1'b1;
          r.read_data = rx_bytes[rx_head];
          rx_head = rx_head + PTR_W'(1);
          rx_fill--;
        end else begin
          read_stalled = 1'b1;
          stall_ticks = '0;
        end
      end else if (op == OP_READ) begin
        r.read_valid = 1'b1;
        r.read_data = STAT_CONST | (rx_fill > 0 ? STAT_NOT_EMPTY : 8'h00)
                      | (underrun_seen ? STAT_UNDERRUN : 8'h00);
        underrun_seen = 1'b0;
      end else if (port == PORT_DATA) begin
        if (data_byte <= CMD_MAX_SPEED) begin
          speed_sel = data_byte[3:0];
        end else if (data_byte == CMD_CLEAR) begin
          rx_head = '0;
          rx_tail = '0;
          rx_fill = 0;
          underrun_seen = 1'b0;
        end
      end else begin
        r.tx_valid = 1'b1;
        r.tx_byte = data_byte;
      end
    end
    r.cpu_wait = read_stalled;
    r.baud_rate = rate_for(speed_sel);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [39:0] got,
                                 input logic [39:0] exp);
    if (mismatch_count < 30)
      $display("%0t ns: %s mismatch, got %0h, expected %0h", $time, what, got, exp);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (reply_wr == reply_rd) begin
        report_mismatch("unexpected transfer", out_tdata, 40'h0);
      end else begin
        want = awaited_replies[reply_rd[3:0]];
        reply_rd = reply_rd + 5'd1;
        if (out_tdata[0] !== want.read_valid)
          report_mismatch("read_valid", 40'(out_tdata[0]), 40'(want.read_valid));
        if (out_tdata[8:1] !== want.read_data)
          report_mismatch("read_data", 40'(out_tdata[8:1]), 40'(want.read_data));
        if (out_tdata[9] !== want.tx_valid)
          report_mismatch("tx_valid", 40'(out_tdata[9]), 40'(want.tx_valid));
        if (out_tdata[17:10] !== want.tx_byte)
          report_mismatch("tx_byte", 40'(out_tdata[17:10]), 40'(want.tx_byte));
        if (out_tdata[18] !== want.cpu_wait)
          report_mismatch("cpu_wait", 40'(out_tdata[18]), 40'(want.cpu_wait));
        if (out_tdata[38:19] !== want.baud_rate)
          report_mismatch("baud_rate", 40'(out_tdata[38:19]), 40'(want.baud_rate));
        if (out_tdata[39] !== want.rx_dropped)
          report_mismatch("rx_dropped", 40'(out_tdata[39]), 40'(want.rx_dropped));
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (idling && $urandom_range(0, 7) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
        out_tready <= 1'b1;
      end
    end
  end

  task automatic send_item(input logic [1:0] op, input logic port, input logic [7:0] data_byte);
    if (idling && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= data_byte;
    in_tuser <= {port, op};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    awaited_replies[reply_wr[3:0]] = port_block_step(op, port, data_byte);
    reply_wr = reply_wr + 5'd1;
  endtask

  task automatic wait_for_drain();
    in_tvalid <= 1'b0;
    while (reply_wr != reply_rd) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_timeout(input logic [19:0] ticks);
    wait_for_drain();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= ticks;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    timeout_ticks = ticks;
  endtask

  task automatic test_reset_timeout();
    idling = 1'b0;
    send_item(OP_READ, PORT_DATA, 8'h00);
    repeat (20) send_item(OP_TICK, PORT_DATA, 8'h00);
    send_item(OP_RX_BYTE, PORT_STATUS, 8'h96);
    send_item(OP_READ, PORT_STATUS, 8'h00);
    send_item(OP_READ, PORT_STATUS, 8'h00);
  endtask

  task automatic test_port_access();
    idling = 1'b1;
    send_item(OP_RX_BYTE, PORT_DATA, 8'h00);
    send_item(OP_RX_BYTE, PORT_STATUS, 8'hFF);
    send_item(OP_READ, PORT_STATUS, 8'h00);
    send_item(OP_READ, PORT_DATA, 8'h00);
    send_item(OP_READ, PORT_DATA, 8'hFF);
    send_item(OP_READ, PORT_STATUS, 8'h00);
    send_item(OP_WRITE, PORT_DATA, CMD_MAX_SPEED);
    send_item(OP_WRITE, PORT_DATA, 8'd10);
    send_item(OP_WRITE, PORT_DATA, 8'd21);
    send_item(OP_WRITE, PORT_DATA, 8'hFF);
    send_item(OP_WRITE, PORT_DATA, 8'd0);
    send_item(OP_WRITE, PORT_STATUS, 8'h00);
    send_item(OP_WRITE, PORT_STATUS, 8'hFF);
    send_item(OP_TICK, PORT_DATA, 8'h00);
    send_item(OP_RX_BYTE, PORT_DATA, 8'hA5);
    send_item(OP_RX_BYTE, PORT_DATA, 8'h5A);
    send_item(OP_WRITE, PORT_DATA, CMD_CLEAR);
    send_item(OP_READ, PORT_STATUS, 8'h00);
  endtask

  task automatic test_stall_handling();
    write_timeout(20'd1);
    send_item(OP_READ, PORT_DATA, 8'h00);
    send_item(OP_WRITE, PORT_STATUS, 8'h77);
    send_item(OP_READ, PORT_STATUS, 8'h00);
    send_item(OP_WRITE, PORT_DATA, 8'd5);
    send_item(OP_READ, PORT_DATA, 8'h00);
    send_item(OP_RX_BYTE, PORT_STATUS, 8'h3C);
    send_item(OP_READ, PORT_DATA, 8'h00);
    send_item(OP_TICK, PORT_DATA, 8'h00);
    send_item(OP_READ, PORT_STATUS, 8'h00);
    write_timeout(20'd0);
    send_item(OP_READ, PORT_DATA, 8'h00);
    send_item(OP_TICK, PORT_DATA, 8'h00);
    write_timeout(20'hFFFFF);
    send_item(OP_READ, PORT_DATA, 8'h00);
    repeat (5) send_item(OP_TICK, PORT_STATUS, 8'h00);
    send_item(OP_RX_BYTE, PORT_DATA, 8'hC3);
    write_timeout(20'd2);
    send_item(OP_READ, PORT_DATA, 8'h00);
    send_item(OP_TICK, PORT_DATA, 8'h00);
    send_item(OP_TICK, PORT_DATA, 8'h00);
    send_item(OP_READ, PORT_STATUS, 8'h00);
  endtask

  task automatic test_fifo_traffic();
    idling = 1'b0;
    repeat (64) send_item(OP_RX_BYTE, 1'($urandom_range(0, 1)), 8'($urandom));
    send_item(OP_READ, PORT_STATUS, 8'h00);
    idling = 1'b1;
    repeat (64) send_item(OP_READ, PORT_DATA, 8'($urandom));
    send_item(OP_READ, PORT_STATUS, 8'h00);
    idling = 1'b0;
    repeat (60) send_item(OP_RX_BYTE, PORT_DATA, 8'($urandom));
    repeat (20) send_item(OP_READ, PORT_DATA, 8'h00);
    send_item(OP_WRITE, PORT_DATA, CMD_CLEAR);
    send_item(OP_READ, PORT_STATUS, 8'h00);
    idling = 1'b1;
  endtask

  task automatic random_item();
    int         sel;
    logic [1:0] op;
    logic       port;
    logic [7:0] data_byte;
    sel = $urandom_range(0, 99);
    port = 1'($urandom_range(0, 1));
    data_byte = 8'($urandom);
    if (read_stalled) begin
      if (sel < 55) op = OP_TICK;
      else if (sel < 75) op = OP_RX_BYTE;
      else op = 2'($urandom_range(0, 3));
    end else if (sel < 30) begin
      op = OP_RX_BYTE;
    end else if (sel < 55) begin
      op = OP_READ;
      port = PORT_DATA;
    end else if (sel < 63) begin
      op = OP_READ;
      port = PORT_STATUS;
    end else if (sel < 73) begin
      op = OP_TICK;
    end else if (sel < 85) begin
      op = OP_WRITE;
      port = PORT_DATA;
      case ($urandom_range(0, 3))
        0, 1:    data_byte = 8'($urandom_range(0, 9));
        2:       data_byte = CMD_CLEAR;
        default: data_byte = 8'($urandom);
      endcase
    end else begin
      op = OP_WRITE;
      port = PORT_STATUS;
    end
    send_item(op, port, data_byte);
  endtask

  task automatic test_random_traffic();
    write_timeout(20'd1);
    repeat (70) random_item();
    write_timeout(20'd0);
    repeat (60) random_item();
    write_timeout(20'hFFFFF);
    repeat (60) random_item();
    write_timeout(20'($urandom_range(2, 6)));
    repeat (80) random_item();
    write_timeout(20'd3);
    idling = 1'b0;
    repeat (95) random_item();
  endtask

  initial begin
    rx_head = '0;
    rx_tail = '0;
    rx_fill = 0;
    underrun_seen = 1'b0;
    read_stalled = 1'b0;
    speed_sel = '0;
    stall_ticks = '0;
    timeout_ticks = TIMEOUT_RESET;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_timeout();
    test_port_access();
    test_stall_handling();
    test_fifo_traffic();
    test_random_traffic();
    wait_for_drain();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
